// ===== sv/pmpp_pkg.sv =====
// ============================================================================
// pmpp_pkg
// Shared types, register codes and helpers for the palette-match packer.
// ============================================================================
package pmpp_pkg;

    localparam int RGB_W      = 24;
    localparam int SLOT_W     = 4;
    localparam int IDX_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int BPP_W      = 3;
    localparam int COLORS_W   = 5;
    localparam int ROW_W      = 9;
    localparam int IMG_W      = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int MAX_ROW_PIXELS_DEF  = 256;

    localparam logic [BPP_W-1:0]    BPP_RST    = 3'd1;
    localparam logic [COLORS_W-1:0] COLORS_RST = 5'd2;
    localparam logic [ROW_W-1:0]    ROW_RST    = 9'd8;
    localparam logic [IMG_W-1:0]    IMG_RST    = 11'd64;

    localparam logic [0:0] CMD_PIXEL = 1'b0;
    localparam logic [0:0] CMD_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPP    = 2'd0,
        CFG_COLORS = 2'd1,
        CFG_ROW    = 2'd2,
        CFG_WIDTH  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [0:0]        cmd;
        logic [RGB_W-1:0]  pixel_rgb;
        logic [SLOT_W-1:0] slot;
        logic [RGB_W-1:0]  entry_rgb;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              row_end;
    } t_out_item;

    // Packing controls handed to the back end
    typedef struct packed {
        logic [BPP_W-1:0] bpp;
        logic [ROW_W-1:0] row_pixels;
        logic [IMG_W-1:0] image_width;
    } t_pack_cfg;

    // 0 acts as 1, 5..7 act as 4
    function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] bpp);
        logic [BPP_W-1:0] r;
        case (bpp)
            3'd0:                      r = 3'd1;
            3'd1, 3'd2, 3'd3, 3'd4:    r = bpp;
            default:                   r = 3'd4;
        endcase
        return r;
    endfunction

    // ceil(8 / bpp) for an effective bpp
    function automatic logic [3:0] per_byte(input logic [BPP_W-1:0] bpp);
        logic [3:0] r;
        case (bpp)
            3'd1:    r = 4'd8;
            3'd2:    r = 4'd4;
            3'd3:    r = 4'd3;
            default: r = 4'd2;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/pmpp_fifo.sv =====
// ============================================================================
// pmpp_fifo
// Small first-word-fall-through queue, register storage.
// ============================================================================
module pmpp_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr, w_rd;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_wr      = i_wr_en && !o_full;
    assign w_rd      = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr_en && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && o_empty))
        else $error("queue read while empty");
`endif

endmodule

// ===== sv/pmpp_front.sv =====
// ============================================================================
// pmpp_front
// Palette store and match: classifies each item, writes the palette or
// turns a pixel into its raw palette index.
// ============================================================================
module pmpp_front #(
    parameter int PALETTE_ENTRIES = pmpp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_accept,
    input  pmpp_pkg::t_in_item                  i_item,
    input  logic [pmpp_pkg::COLORS_W-1:0]       i_color_count,
    output logic                                o_q_push,
    output logic [pmpp_pkg::IDX_W-1:0]          o_q_idx
);

    localparam int PI_W = $clog2(PALETTE_ENTRIES);

    logic [pmpp_pkg::RGB_W-1:0]    r_palette [PALETTE_ENTRIES];
    logic [pmpp_pkg::COLORS_W-1:0] w_count;
    logic [pmpp_pkg::IDX_W-1:0]    w_idx;
    logic                          w_is_write;

    assign w_is_write = (i_item.cmd == pmpp_pkg::CMD_WRITE);

    // Saturate the active entry count to the palette size
    always_comb begin
        if (i_color_count > pmpp_pkg::COLORS_W'(PALETTE_ENTRIES)) begin
            w_count = pmpp_pkg::COLORS_W'(PALETTE_ENTRIES);
        end else begin
            w_count = i_color_count;
        end
    end

    // First matching entry wins: scan from the top so lower slots override
    always_comb begin
        w_idx = '0;
        for (int k = PALETTE_ENTRIES - 1; k >= 0; k--) begin
            if ((pmpp_pkg::COLORS_W'(k) < w_count) && (r_palette[k] == i_item.pixel_rgb)) begin
                w_idx = pmpp_pkg::IDX_W'(k);
            end
        end
    end

    assign o_q_push = i_accept && !w_is_write;
    assign o_q_idx  = w_idx;

    // Slots past the palette are dropped
    always_ff @(posedge i_clk) begin
        if (i_accept && w_is_write &&
            ({1'b0, i_item.slot} < (pmpp_pkg::SLOT_W + 1)'(PALETTE_ENTRIES))) begin
            r_palette[i_item.slot[PI_W-1:0]] <= i_item.entry_rgb;
        end
    end

endmodule

// ===== sv/pmpp_back.sv =====
// ============================================================================
// pmpp_back
// Bit packer: applies the column bound, ORs indices into the byte and
// emits bytes with the row-end flag.
// ============================================================================
module pmpp_back #(
    parameter int MAX_ROW_PIXELS = pmpp_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pmpp_pkg::t_pack_cfg             i_cfg,
    input  logic                            i_q_valid,
    input  logic [pmpp_pkg::IDX_W-1:0]      i_q_idx,
    output logic                            o_q_pop,
    input  logic                            i_out_full,
    output logic                            o_out_push,
    output pmpp_pkg::t_out_item             o_out_item
);

    localparam int COL_W = $clog2(MAX_ROW_PIXELS + 1);
    localparam int CW    = ((COL_W > pmpp_pkg::IMG_W) ? COL_W : pmpp_pkg::IMG_W) + 1;

    logic [pmpp_pkg::BYTE_W-1:0] r_acc, n_acc;
    logic [2:0]                  r_pib, n_pib;
    logic [COL_W-1:0]            r_col, n_col;

    logic                        w_fire, w_emit, w_last, w_in_bounds;
    logic [pmpp_pkg::BPP_W-1:0]  w_bpp;
    logic [3:0]                  w_per_byte, w_pib_next;
    logic [CW-1:0]               w_row_len, w_row_raw, w_col_next;
    logic [4:0]                  w_shift;
    logic [11:0]                 w_shifted;
    logic [pmpp_pkg::IDX_W-1:0]  w_idx;
    logic [pmpp_pkg::BYTE_W-1:0] w_acc_or;

    assign w_bpp      = pmpp_pkg::eff_bpp(i_cfg.bpp);
    assign w_per_byte = pmpp_pkg::per_byte(w_bpp);
    assign w_row_raw  = CW'(i_cfg.row_pixels);

    always_comb begin
        if (w_row_raw == '0) begin
            w_row_len = CW'(1);
        end else if (w_row_raw > CW'(MAX_ROW_PIXELS)) begin
            w_row_len = CW'(MAX_ROW_PIXELS);
        end else begin
            w_row_len = w_row_raw;
        end
    end

    assign w_in_bounds = (CW'(r_col) < CW'(i_cfg.image_width));
    assign w_idx       = w_in_bounds ? i_q_idx : '0;
    assign w_shift     = 5'(r_pib) * 5'(w_bpp);
    assign w_shifted   = 12'(w_idx) << w_shift[2:0];
    // Index bits past bit 7 fall off
    assign w_acc_or    = (w_shift < 5'd8) ? (r_acc | w_shifted[7:0]) : r_acc;

    assign w_pib_next  = 4'(r_pib) + 4'd1;
    assign w_col_next  = CW'(r_col) + CW'(1);
    assign w_last      = (w_col_next >= w_row_len);
    assign w_emit      = (w_pib_next >= w_per_byte) || w_last;

    assign w_fire      = i_q_valid && !i_out_full;
    assign o_q_pop     = w_fire;
    assign o_out_push  = w_fire && w_emit;

    assign o_out_item.packed_byte = w_acc_or;
    assign o_out_item.row_end     = w_last;

    always_comb begin
        n_acc = r_acc;
        n_pib = r_pib;
        n_col = r_col;
        if (w_fire) begin
            n_acc = w_emit ? '0 : w_acc_or;
            n_pib = w_emit ? '0 : w_pib_next[2:0];
            n_col = w_last ? '0 : w_col_next[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_pib <= '0;
            r_col <= '0;
        end else begin
            r_acc <= n_acc;
            r_pib <= n_pib;
            r_col <= n_col;
        end
    end

`ifndef SYNTHESIS
    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_out_item.row_end) |=> (r_col == '0 && r_pib == '0 && r_acc == '0))
        else $error("row end did not clear packing state");
`endif

endmodule

// ===== sv/palette_match_pixel_packer_top.sv =====
// A byte-closing pixel's index passes the index queue and packer into the result queue,
// then shows on o_out. Throughput: one item per cycle while the result queue has room;
// the packer drains the 4-entry index queue one entry per cycle into a 2-entry queue.
// Palette writes are stored in the front end and produce no result.
// Reset (i_rst_n low, synchronous) clears queues, packing counters and config to
// their defaults; palette contents are undefined until written.
// ============================================================================
// palette_match_pixel_packer_top
// Palette match and index bit packer: front end matches pixels against the
// palette, back end packs indices into bytes with a row-end flag.
// ============================================================================
module palette_match_pixel_packer_top #(
    parameter int PALETTE_ENTRIES = pmpp_pkg::PALETTE_ENTRIES_DEF,
    parameter int MAX_ROW_PIXELS  = pmpp_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input queue side
    input  logic                                push,
    output logic                                full,
    input  pmpp_pkg::t_in_item                  i_in,
    // result queue side
    output logic                                empty,
    input  logic                                pop,
    output pmpp_pkg::t_out_item                 o_out,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pmpp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pmpp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int Q_DEPTH   = 4;
    localparam int OUT_DEPTH = 2;
    localparam int OUT_W     = $bits(pmpp_pkg::t_out_item);

    // Config registers
    logic [pmpp_pkg::BPP_W-1:0]    r_bpp;
    logic [pmpp_pkg::COLORS_W-1:0] r_color_count;
    logic [pmpp_pkg::ROW_W-1:0]    r_row_pixels;
    logic [pmpp_pkg::IMG_W-1:0]    r_image_width;

    logic                          w_accept;
    logic                          w_q_push, w_q_pop, w_q_full, w_q_empty;
    logic [pmpp_pkg::IDX_W-1:0]    w_front_idx, w_q_idx;
    logic                          w_out_push, w_out_full;
    pmpp_pkg::t_out_item           w_back_item;
    logic [OUT_W-1:0]              w_out_data;
    pmpp_pkg::t_pack_cfg           w_pack_cfg;

    // Always ready; the host writes only while no item is in flight (not enforced here)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp         <= pmpp_pkg::BPP_RST;
            r_color_count <= pmpp_pkg::COLORS_RST;
            r_row_pixels  <= pmpp_pkg::ROW_RST;
            r_image_width <= pmpp_pkg::IMG_RST;
        end else if (i_cfg_valid) begin
            unique case (pmpp_pkg::t_cfg_reg'(i_cfg_index))
                pmpp_pkg::CFG_BPP:    r_bpp         <= i_cfg_data[pmpp_pkg::BPP_W-1:0];
                pmpp_pkg::CFG_COLORS: r_color_count <= i_cfg_data[pmpp_pkg::COLORS_W-1:0];
                pmpp_pkg::CFG_ROW:    r_row_pixels  <= i_cfg_data[pmpp_pkg::ROW_W-1:0];
                pmpp_pkg::CFG_WIDTH:  r_image_width <= i_cfg_data[pmpp_pkg::IMG_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_pack_cfg.bpp         = r_bpp;
    assign w_pack_cfg.row_pixels  = r_row_pixels;
    assign w_pack_cfg.image_width = r_image_width;

    // Input side: full tracks the index queue, even for palette writes
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // Front end: palette store + match
    pmpp_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk         (i_clk),
        .i_accept      (w_accept),
        .i_item        (i_in),
        .i_color_count (r_color_count),
        .o_q_push      (w_q_push),
        .o_q_idx       (w_front_idx)
    );

    // Decoupling queue of raw indices
    pmpp_fifo #(
        .WIDTH (pmpp_pkg::IDX_W),
        .DEPTH (Q_DEPTH)
    ) u_idx_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_q_push),
        .i_wr_data (w_front_idx),
        .i_rd_en   (w_q_pop),
        .o_rd_data (w_q_idx),
        .o_full    (w_q_full),
        .o_empty   (w_q_empty)
    );

    // Back end: column bound, bit packing, byte emit
    pmpp_back #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_pack_cfg),
        .i_q_valid  (!w_q_empty),
        .i_q_idx    (w_q_idx),
        .o_q_pop    (w_q_pop),
        .i_out_full (w_out_full),
        .o_out_push (w_out_push),
        .o_out_item (w_back_item)
    );

    // Result queue: lets the packer keep going while a byte waits
    pmpp_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_out_push),
        .i_wr_data (w_back_item),
        .i_rd_en   (pop && !empty),
        .o_rd_data (w_out_data),
        .o_full    (w_out_full),
        .o_empty   (empty)
    );

    assign o_out = pmpp_pkg::t_out_item'(w_out_data);

endmodule
